FILE: rtl/ust_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the UV sphere tessellator.
// Depends on nothing; every other file of the block but ust_delay imports it.
package ust_pkg;

   localparam int MAX_DIVISIONS = 256;
   localparam int STACK_MIN = 2;
   localparam int SLICE_MIN = 3;
   localparam int CORDIC_STEPS = 24;
   localparam int DIV_STEPS = 17;
   localparam int DVD_W = 25;
   localparam int DVS_W = 10;
   localparam int REM_W = 27;
   localparam int CX_W = 33;
   localparam int CZ_W = 32;
   localparam logic signed [CX_W-1:0] CORDIC_START = 33'sd652032875;
   localparam logic signed [15:0] Q14_ONE = 16'sd16384;
   localparam logic [16:0] TEX_HALF = 17'd32768;
   localparam logic [16:0] TEX_ONE = 17'd65536;

   localparam logic OP_VERTEX = 1'b0;
   localparam logic OP_TRIANGLE = 1'b1;

   localparam logic [1:0] CSR_RADIUS = 2'd0;
   localparam logic [1:0] CSR_STACKS = 2'd1;
   localparam logic [1:0] CSR_SLICES = 2'd2;

   typedef struct packed {
      logic        op;
      logic        bad;
      logic        pole_n;
      logic        pole_s;
      logic [16:0] corner_a;
      logic [16:0] corner_b;
      logic [16:0] corner_c;
   } meta_type;

   // Arctangent of 2^-k as a fraction of a turn, a quarter turn being 2^30.
   function automatic logic signed [CZ_W-1:0] atan_turn(input logic [4:0] k);
      logic signed [CZ_W-1:0] a;
      unique case (k)
         5'd0: a = 32'sd536870912;
         5'd1: a = 32'sd316933406;
         5'd2: a = 32'sd167458907;
         5'd3: a = 32'sd85004756;
         5'd4: a = 32'sd42667331;
         5'd5: a = 32'sd21354465;
         5'd6: a = 32'sd10679838;
         5'd7: a = 32'sd5340245;
         5'd8: a = 32'sd2670163;
         5'd9: a = 32'sd1335087;
         5'd10: a = 32'sd667544;
         5'd11: a = 32'sd333772;
         5'd12: a = 32'sd166886;
         5'd13: a = 32'sd83443;
         5'd14: a = 32'sd41722;
         5'd15: a = 32'sd20861;
         5'd16: a = 32'sd10430;
         5'd17: a = 32'sd5215;
         5'd18: a = 32'sd2608;
         5'd19: a = 32'sd1304;
         5'd20: a = 32'sd652;
         5'd21: a = 32'sd326;
         5'd22: a = 32'sd163;
         5'd23: a = 32'sd81;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

FILE: rtl/ust_delay.sv
// Fixed-length delay line with a common advance enable.
// Depends on nothing.
module ust_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

FILE: rtl/ust_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ust_pkg for widths.
module ust_divider (
   input  logic                      clock,
   input  logic                      en,
   input  logic [ust_pkg::DVD_W-1:0] dividend,
   input  logic [ust_pkg::DVS_W-1:0] divisor,
   output logic [16:0]               quotient
);
   import ust_pkg::*;

   logic [DVD_W-1:0] rem_ff [DIV_STEPS];
   logic [16:0]      quo_ff [DIV_STEPS];
   logic [DVS_W-1:0] dvs_ff [DIV_STEPS];

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      logic [DVD_W-1:0] rem_p, rem_n;
      logic [16:0]      quo_p, quo_n;
      logic [DVS_W-1:0] dvs_p;
      logic [REM_W-1:0] trial;

      if (s == 0) begin : g_first
         assign rem_p = dividend;
         assign quo_p = '0;
         assign dvs_p = divisor;
      end else begin : g_next
         assign rem_p = rem_ff[s-1];
         assign quo_p = quo_ff[s-1];
         assign dvs_p = dvs_ff[s-1];
      end

      always_comb begin
         trial = {{(REM_W-DVD_W){1'b0}}, rem_p}
               - ({{(REM_W-DVS_W){1'b0}}, dvs_p} << (DIV_STEPS-1-s));
         rem_n = rem_p;
         quo_n = quo_p;
         if (!trial[REM_W-1]) begin
            rem_n = trial[DVD_W-1:0];
            quo_n[DIV_STEPS-1-s] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_n;
            quo_ff[s] <= quo_n;
            dvs_ff[s] <= dvs_p;
         end
      end
   end

   assign quotient = quo_ff[DIV_STEPS-1];

endmodule

FILE: rtl/ust_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, on a 16-bit phase.
// Depends on ust_pkg for widths, start vector and the arctangent table.
module ust_cordic (
   input  logic                            clock,
   input  logic                            en,
   input  logic [15:0]                     phase,
   output logic signed [ust_pkg::CX_W-1:0] x_out,
   output logic signed [ust_pkg::CX_W-1:0] y_out,
   output logic [1:0]                      quad
);
   import ust_pkg::*;

   logic signed [CX_W-1:0] x_ff [CORDIC_STEPS];
   logic signed [CX_W-1:0] y_ff [CORDIC_STEPS];
   logic signed [CZ_W-1:0] z_ff [CORDIC_STEPS];
   logic [1:0]             q_ff [CORDIC_STEPS];

   for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
      logic signed [CX_W-1:0] x_p, y_p, x_n, y_n;
      logic signed [CZ_W-1:0] z_p, z_n;
      logic [1:0]             q_p;

      if (s == 0) begin : g_first
         assign x_p = CORDIC_START;
         assign y_p = '0;
         assign z_p = signed'({2'b00, phase[13:0], 16'h0000});
         assign q_p = phase[15:14];
      end else begin : g_next
         assign x_p = x_ff[s-1];
         assign y_p = y_ff[s-1];
         assign z_p = z_ff[s-1];
         assign q_p = q_ff[s-1];
      end

      always_comb begin
         if (!z_p[CZ_W-1]) begin
            x_n = x_p - (y_p >>> s);
            y_n = y_p + (x_p >>> s);
            z_n = z_p - atan_turn(5'(s));
         end else begin
            x_n = x_p + (y_p >>> s);
            y_n = y_p - (x_p >>> s);
            z_n = z_p + atan_turn(5'(s));
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[s] <= x_n;
            y_ff[s] <= y_n;
            z_ff[s] <= z_n;
            q_ff[s] <= q_p;
         end
      end
   end

   assign x_out = x_ff[CORDIC_STEPS-1];
   assign y_out = y_ff[CORDIC_STEPS-1];
   assign quad  = q_ff[CORDIC_STEPS-1];

endmodule

FILE: rtl/ust_shade.sv
// Quadrant fix-up, Q1.14 rounding and the normal and position products, three stages.
// Depends on ust_pkg for widths and constants.
module ust_shade (
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [ust_pkg::CX_W-1:0] ring_x,
   input  logic signed [ust_pkg::CX_W-1:0] ring_y,
   input  logic [1:0]                      ring_quad,
   input  logic signed [ust_pkg::CX_W-1:0] slice_x,
   input  logic signed [ust_pkg::CX_W-1:0] slice_y,
   input  logic [1:0]                      slice_quad,
   input  logic [15:0]                     radius,
   output logic signed [16:0]              pos_x,
   output logic signed [16:0]              pos_y,
   output logic signed [16:0]              pos_z,
   output logic signed [15:0]              norm_x,
   output logic signed [15:0]              norm_y,
   output logic signed [15:0]              norm_z
);
   import ust_pkg::*;

   function automatic logic signed [15:0] to_q14(input logic signed [CX_W-1:0] v);
      logic signed [CX_W-1:0] r;
      r = (v + 33'sd32768) >>> 16;
      if (r > 33'sd16384) return Q14_ONE;
      if (r < -33'sd16384) return -Q14_ONE;
      return r[15:0];
   endfunction

   function automatic logic signed [15:0] pick_cos(input logic [1:0] q,
         input logic signed [CX_W-1:0] x, input logic signed [CX_W-1:0] y);
      logic signed [CX_W-1:0] c;
      unique case (q)
         2'd0: c = x;
         2'd1: c = -y;
         2'd2: c = -x;
         2'd3: c = y;
         default: c = x;
      endcase
      return to_q14(c);
   endfunction

   function automatic logic signed [15:0] pick_sin(input logic [1:0] q,
         input logic signed [CX_W-1:0] x, input logic signed [CX_W-1:0] y);
      logic signed [CX_W-1:0] s;
      unique case (q)
         2'd0: s = y;
         2'd1: s = x;
         2'd2: s = -y;
         2'd3: s = -x;
         default: s = y;
      endcase
      return to_q14(s);
   endfunction

   logic signed [15:0] sp_ff, cp_ff, st_ff, ct_ff;
   logic signed [31:0] tx_ff, tz_ff;
   logic signed [15:0] nx_ff, ny_ff, nz_ff, nx2_ff, ny2_ff, nz2_ff;
   logic signed [16:0] py_ff, py2_ff, px_ff, pz_ff;
   logic signed [16:0] rad_s;
   logic signed [31:0] prod_x, prod_z, rnd_x, rnd_z;
   logic signed [32:0] prod_y, rnd_y;
   logic signed [48:0] big_x, big_z, rbig_x, rbig_z;

   assign rad_s = signed'({1'b0, radius});

   always_comb begin
      prod_x = sp_ff * st_ff;
      prod_z = sp_ff * ct_ff;
      prod_y = rad_s * cp_ff;
      rnd_x = (prod_x + 32'sd8192) >>> 14;
      rnd_z = (prod_z + 32'sd8192) >>> 14;
      rnd_y = (prod_y + 33'sd8192) >>> 14;
      big_x = rad_s * tx_ff;
      big_z = rad_s * tz_ff;
      rbig_x = (big_x + 49'sd134217728) >>> 28;
      rbig_z = (big_z + 49'sd134217728) >>> 28;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sp_ff <= pick_sin(ring_quad, ring_x, ring_y);
         cp_ff <= pick_cos(ring_quad, ring_x, ring_y);
         st_ff <= pick_sin(slice_quad, slice_x, slice_y);
         ct_ff <= pick_cos(slice_quad, slice_x, slice_y);
         tx_ff <= prod_x;
         tz_ff <= prod_z;
         nx_ff <= rnd_x[15:0];
         nz_ff <= rnd_z[15:0];
         ny_ff <= cp_ff;
         py_ff <= rnd_y[16:0];
         px_ff <= rbig_x[16:0];
         pz_ff <= rbig_z[16:0];
         py2_ff <= py_ff;
         nx2_ff <= nx_ff;
         ny2_ff <= ny_ff;
         nz2_ff <= nz_ff;
      end
   end

   assign pos_x  = px_ff;
   assign pos_y  = py2_ff;
   assign pos_z  = pz_ff;
   assign norm_x = nx2_ff;
   assign norm_y = ny2_ff;
   assign norm_z = nz2_ff;

endmodule

FILE: rtl/uv_sphere_tessellator.sv
// UV sphere tessellator: returns one vertex or one triangle of a UV sphere per request.
// Top level; depends on ust_pkg, ust_delay, ust_divider, ust_cordic and ust_shade.
//
// Use: a request transfers on req_* when req_valid is high and req_stall is low.
// op selects a vertex (ring, slice) or a triangle (band, slice, quad half). Each
// request yields exactly one response on rsp_*, transferred when rsp_valid is high
// and rsp_stall is low. Out-of-range requests return bad_index with all else zero.
// Configuration (radius, stack count, slice count) is written on csr_*, which is
// always ready; counts are clamped on write. Write it only while the block is idle.
//
// A request passes through 17 divider stages (one quotient bit each) that produce the
// angle phases and texture coordinates, 24 CORDIC stages (one micro-rotation each)
// that produce sine and cosine, three stages that round and multiply, and one output
// register that holds the response.
// Throughput is one request per cycle unless the output is stalled. The whole pipeline
// advances together while the output register is empty or being taken; a stall on
// rsp_stall freezes every stage and raises req_stall, so nothing is lost or repeated.
// Synchronous reset clears all valid bits and restores radius 1.0, 16 stacks and
// 16 slices.
module uv_sphere_tessellator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [8:0]         req_ring_or_band,
   input  logic [8:0]         req_slice_number,
   input  logic               req_quad_half,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [16:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic [16:0]        rsp_corner_a,
   output logic [16:0]        rsp_corner_b,
   output logic [16:0]        rsp_corner_c,
   output logic               rsp_bad_index,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import ust_pkg::*;

   // Total pipeline depth in front of the output register.
   localparam int PIPE_DEPTH = DIV_STEPS + CORDIC_STEPS + 3;
   localparam int TEX_DEPTH = CORDIC_STEPS + 3;
   localparam int META_W = $bits(meta_type);

   // Configuration registers.
   logic [15:0] radius_ff;
   logic [8:0]  stacks_ff, slices_ff;
   logic [8:0]  csr_count;

   assign csr_ready = 1'b1;
   assign csr_count = csr_wdata[8:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 16'd256;
         stacks_ff <= 9'd16;
         slices_ff <= 9'd16;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RADIUS: radius_ff <= csr_wdata;
            CSR_STACKS: begin
               if (csr_count < 9'(STACK_MIN)) stacks_ff <= 9'(STACK_MIN);
               else if (csr_count > 9'(MAX_DIVISIONS)) stacks_ff <= 9'(MAX_DIVISIONS);
               else stacks_ff <= csr_count;
            end
            CSR_SLICES: begin
               if (csr_count < 9'(SLICE_MIN)) slices_ff <= 9'(SLICE_MIN);
               else if (csr_count > 9'(MAX_DIVISIONS)) slices_ff <= 9'(MAX_DIVISIONS);
               else slices_ff <= csr_count;
            end
            default: begin
            end
         endcase
      end
   end

   // The pipeline moves as one while the output register can take a new item.
   logic adv;
   logic rsp_valid_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Entry: range checks, pole detection and triangle corner indices.
   meta_type    meta_in, meta_out;
   logic [17:0] row_prod;
   logic [16:0] top, bot, top_sl, bot_sl;
   logic [8:0]  rb_less;

   always_comb begin
      rb_less = req_ring_or_band - 9'd1;
      row_prod = rb_less * (slices_ff + 9'd1);
      top = row_prod[16:0] + 17'd1;
      bot = top + {8'd0, slices_ff} + 17'd1;
      top_sl = top + {8'd0, req_slice_number};
      bot_sl = bot + {8'd0, req_slice_number};

      meta_in = '0;
      meta_in.op = req_op;
      if (req_op == OP_VERTEX) begin
         meta_in.bad = (req_ring_or_band > stacks_ff) || (req_slice_number > slices_ff);
         meta_in.pole_n = (req_ring_or_band == 9'd0);
         meta_in.pole_s = (req_ring_or_band == stacks_ff);
      end else begin
         meta_in.bad = (req_ring_or_band >= stacks_ff) || (req_slice_number >= slices_ff);
         if (req_ring_or_band == 9'd0) begin
            // Top fan around the north pole.
            meta_in.corner_a = '0;
            meta_in.corner_b = {8'd0, req_slice_number} + 17'd1;
            meta_in.corner_c = {8'd0, req_slice_number} + 17'd2;
         end else if (req_ring_or_band == stacks_ff - 9'd1) begin
            // Bottom fan around the south pole.
            meta_in.corner_a = top_sl;
            meta_in.corner_b = bot;
            meta_in.corner_c = top_sl + 17'd1;
         end else if (!req_quad_half) begin
            meta_in.corner_a = top_sl;
            meta_in.corner_b = bot_sl;
            meta_in.corner_c = top_sl + 17'd1;
         end else begin
            meta_in.corner_a = bot_sl;
            meta_in.corner_b = bot_sl + 17'd1;
            meta_in.corner_c = top_sl + 17'd1;
         end
      end
   end

   // Valid bits travel alongside the payload.
   logic [PIPE_DEPTH-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   logic [META_W-1:0] meta_bits;

   ust_delay #(.WIDTH(META_W), .DEPTH(PIPE_DEPTH)) u_meta_dly (
      .clock (clock),
      .en    (adv),
      .din   (meta_in),
      .dout  (meta_bits)
   );

   assign meta_out = meta_type'(meta_bits);

   // Dividers: ring phase (ring over twice the stacks), texture v and texture u.
   // The slice phase is the low 16 bits of texture u.
   logic [DVD_W-1:0] dvd_ring, dvd_v, dvd_u;
   logic [16:0]      q_ring, q_v, q_u;

   assign dvd_ring = {req_ring_or_band, 16'h0000} + {16'd0, stacks_ff};
   assign dvd_v    = {req_ring_or_band, 16'h0000} + {17'd0, stacks_ff[8:1]};
   assign dvd_u    = {req_slice_number, 16'h0000} + {17'd0, slices_ff[8:1]};

   ust_divider u_div_ring (
      .clock    (clock),
      .en       (adv),
      .dividend (dvd_ring),
      .divisor  ({stacks_ff, 1'b0}),
      .quotient (q_ring)
   );

   ust_divider u_div_v (
      .clock    (clock),
      .en       (adv),
      .dividend (dvd_v),
      .divisor  ({1'b0, stacks_ff}),
      .quotient (q_v)
   );

   ust_divider u_div_u (
      .clock    (clock),
      .en       (adv),
      .dividend (dvd_u),
      .divisor  ({1'b0, slices_ff}),
      .quotient (q_u)
   );

   logic [33:0] tex_bits;

   ust_delay #(.WIDTH(34), .DEPTH(TEX_DEPTH)) u_tex_dly (
      .clock (clock),
      .en    (adv),
      .din   ({q_u, q_v}),
      .dout  (tex_bits)
   );

   // Sine and cosine of the ring and slice angles.
   logic signed [CX_W-1:0] ring_x, ring_y, slice_x, slice_y;
   logic [1:0]             ring_quad, slice_quad;

   ust_cordic u_cordic_ring (
      .clock (clock),
      .en    (adv),
      .phase (q_ring[15:0]),
      .x_out (ring_x),
      .y_out (ring_y),
      .quad  (ring_quad)
   );

   ust_cordic u_cordic_slice (
      .clock (clock),
      .en    (adv),
      .phase (q_u[15:0]),
      .x_out (slice_x),
      .y_out (slice_y),
      .quad  (slice_quad)
   );

   logic signed [16:0] px, py, pz;
   logic signed [15:0] nx, ny, nz;

   ust_shade u_shade (
      .clock      (clock),
      .en         (adv),
      .ring_x     (ring_x),
      .ring_y     (ring_y),
      .ring_quad  (ring_quad),
      .slice_x    (slice_x),
      .slice_y    (slice_y),
      .slice_quad (slice_quad),
      .radius     (radius_ff),
      .pos_x      (px),
      .pos_y      (py),
      .pos_z      (pz),
      .norm_x     (nx),
      .norm_y     (ny),
      .norm_z     (nz)
   );

   // Response assembly and output register.
   logic signed [16:0] pos_x_in, pos_y_in, pos_z_in;
   logic signed [15:0] norm_x_in, norm_y_in, norm_z_in;
   logic [16:0]        tex_u_in, tex_v_in, corner_a_in, corner_b_in, corner_c_in;
   logic               bad_in;
   logic signed [16:0] rad_s;

   logic signed [16:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [15:0] norm_x_ff, norm_y_ff, norm_z_ff;
   logic [16:0]        tex_u_ff, tex_v_ff, corner_a_ff, corner_b_ff, corner_c_ff;
   logic               bad_ff;

   assign rad_s = signed'({1'b0, radius_ff});

   always_comb begin
      pos_x_in = '0;
      pos_y_in = '0;
      pos_z_in = '0;
      norm_x_in = '0;
      norm_y_in = '0;
      norm_z_in = '0;
      tex_u_in = '0;
      tex_v_in = '0;
      corner_a_in = '0;
      corner_b_in = '0;
      corner_c_in = '0;
      bad_in = meta_out.bad;
      if (!meta_out.bad) begin
         if (meta_out.op == OP_TRIANGLE) begin
            corner_a_in = meta_out.corner_a;
            corner_b_in = meta_out.corner_b;
            corner_c_in = meta_out.corner_c;
         end else if (meta_out.pole_n) begin
            pos_y_in = rad_s;
            norm_y_in = Q14_ONE;
            tex_u_in = TEX_HALF;
         end else if (meta_out.pole_s) begin
            pos_y_in = -rad_s;
            norm_y_in = -Q14_ONE;
            tex_u_in = TEX_HALF;
            tex_v_in = TEX_ONE;
         end else begin
            pos_x_in = px;
            pos_y_in = py;
            pos_z_in = pz;
            norm_x_in = nx;
            norm_y_in = ny;
            norm_z_in = nz;
            tex_u_in = tex_bits[33:17];
            tex_v_in = tex_bits[16:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         norm_x_ff <= norm_x_in;
         norm_y_ff <= norm_y_in;
         norm_z_ff <= norm_z_in;
         tex_u_ff <= tex_u_in;
         tex_v_ff <= tex_v_in;
         corner_a_ff <= corner_a_in;
         corner_b_ff <= corner_b_in;
         corner_c_ff <= corner_c_in;
         bad_ff <= bad_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = pos_x_ff;
   assign rsp_pos_y = pos_y_ff;
   assign rsp_pos_z = pos_z_ff;
   assign rsp_norm_x = norm_x_ff;
   assign rsp_norm_y = norm_y_ff;
   assign rsp_norm_z = norm_z_ff;
   assign rsp_tex_u = tex_u_ff;
   assign rsp_tex_v = tex_v_ff;
   assign rsp_corner_a = corner_a_ff;
   assign rsp_corner_b = corner_b_ff;
   assign rsp_corner_c = corner_c_ff;
   assign rsp_bad_index = bad_ff;

endmodule
